// ===== rtl/nvsb_pkg.sv =====
package nvsb_pkg;

  localparam int DIM_W     = 13;
  localparam int POS_W     = 12;
  localparam int MAX_DIM   = 4096;
  localparam int HUE_STEPS = 180;
  localparam int HUE_W     = 8;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd480;

  localparam logic [1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IDX_HEIGHT = 2'd1;

  localparam logic [7:0] BAR_STEP    = 8'd6;
  localparam logic [7:0] BAR_HALF    = 8'd20;
  localparam logic [7:0] BAR_LEVEL   = 8'd235;
  localparam logic [7:0] RAMP_BASE   = 8'd16;
  localparam logic [7:0] RAMP_SPAN   = 8'd200;
  localparam logic [7:0] V_OFFSET    = 8'd45;
  localparam logic [7:0] V_ODD_INDEX = 8'd135;
  localparam logic [7:0] V_ODD_VALUE = 8'd127;

  localparam logic [7:0] U_TABLE [HUE_STEPS] = '{
    8'd128, 8'd131, 8'd134, 8'd138, 8'd141, 8'd145, 8'd148, 8'd152, 8'd155, 8'd158,
    8'd162, 8'd165, 8'd168, 8'd171, 8'd174, 8'd177, 8'd180, 8'd183, 8'd186, 8'd189,
    8'd192, 8'd194, 8'd197, 8'd199, 8'd202, 8'd204, 8'd206, 8'd208, 8'd210, 8'd212,
    8'd214, 8'd216, 8'd217, 8'd219, 8'd220, 8'd221, 8'd223, 8'd224, 8'd225, 8'd225,
    8'd226, 8'd227, 8'd227, 8'd227, 8'd227, 8'd228, 8'd227, 8'd227, 8'd227, 8'd227,
    8'd226, 8'd225, 8'd225, 8'd224, 8'd223, 8'd221, 8'd220, 8'd219, 8'd217, 8'd216,
    8'd214, 8'd212, 8'd210, 8'd208, 8'd206, 8'd204, 8'd202, 8'd199, 8'd197, 8'd194,
    8'd192, 8'd189, 8'd186, 8'd183, 8'd180, 8'd178, 8'd174, 8'd171, 8'd168, 8'd165,
    8'd162, 8'd158, 8'd155, 8'd152, 8'd148, 8'd145, 8'd141, 8'd138, 8'd134, 8'd131,
    8'd128, 8'd124, 8'd121, 8'd117, 8'd114, 8'd110, 8'd107, 8'd103, 8'd100, 8'd97,
    8'd93,  8'd90,  8'd87,  8'd84,  8'd81,  8'd78,  8'd75,  8'd72,  8'd69,  8'd66,
    8'd63,  8'd61,  8'd58,  8'd56,  8'd53,  8'd51,  8'd49,  8'd47,  8'd45,  8'd43,
    8'd41,  8'd39,  8'd38,  8'd36,  8'd35,  8'd34,  8'd32,  8'd31,  8'd30,  8'd30,
    8'd29,  8'd28,  8'd28,  8'd28,  8'd28,  8'd28,  8'd28,  8'd28,  8'd28,  8'd28,
    8'd29,  8'd30,  8'd30,  8'd31,  8'd32,  8'd34,  8'd35,  8'd36,  8'd38,  8'd39,
    8'd41,  8'd43,  8'd45,  8'd47,  8'd49,  8'd51,  8'd53,  8'd56,  8'd58,  8'd61,
    8'd63,  8'd66,  8'd69,  8'd72,  8'd75,  8'd77,  8'd81,  8'd84,  8'd87,  8'd90,
    8'd93,  8'd97,  8'd100, 8'd103, 8'd107, 8'd110, 8'd114, 8'd117, 8'd121, 8'd124
  };

  typedef struct packed {
    logic valid;
    logic restart;
  } nvsb_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic             busy;
    logic             cfg_wr;
    logic             done;
    logic [POS_W-1:0] bar_rem;
    logic [6:0]       ramp_q;
    logic [7:0]       ramp_r;
  } nvsb_geom_t;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic       is_chroma;
    logic       end_of_frame;
  } nvsb_pixel_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v < DIM_W'(2)) r = DIM_W'(2);
    else if (v > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else r = {v[DIM_W-1:1], 1'b0};
    return r;
  endfunction

  function automatic logic [7:0] hue_u(input logic [HUE_W-1:0] k);
    return U_TABLE[k];
  endfunction

  function automatic logic [7:0] hue_v(input logic [HUE_W-1:0] k);
    logic [HUE_W-1:0] idx;
    logic [7:0] r;
    idx = (k >= HUE_W'(HUE_STEPS) - V_OFFSET) ? k - (HUE_W'(HUE_STEPS) - V_OFFSET)
                                               : k + V_OFFSET;
    if (k == V_ODD_INDEX) r = V_ODD_VALUE;
    else r = U_TABLE[idx];
    return r;
  endfunction

endpackage

// ===== rtl/nvsb_front.sv =====
module nvsb_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_restart,
  output logic               in_full,
  input  logic               busy,
  input  logic               item_pop,
  output nvsb_pkg::nvsb_item_t item
);

  logic       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept;

  assign in_full      = (cnt_r == 2'd2) || busy;
  assign accept       = in_push && !in_full;
  assign item.valid   = (cnt_r != 2'd0);
  assign item.restart = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = accept ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = item_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, accept} - {1'b0, item_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_r[wr_ptr_r] <= in_restart;
    end
  end

endmodule

// ===== rtl/nvsb_setup.sv =====
module nvsb_setup (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [nvsb_pkg::DIM_W-1:0]    cfg_data,
  input  logic [nvsb_pkg::POS_W-1:0]    bar_in,
  output nvsb_pkg::nvsb_geom_t          geom
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_BAR  = 2'd2;
  localparam logic [1:0] ST_RAMP = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [3:0]                   cnt_r, cnt_nxt;
  logic [nvsb_pkg::DIM_W-1:0]   width_r, width_nxt;
  logic [nvsb_pkg::DIM_W-1:0]   height_r, height_nxt;
  logic [nvsb_pkg::POS_W-1:0]   dvd_r, dvd_nxt;
  logic [nvsb_pkg::POS_W-1:0]   rem_r, rem_nxt;
  logic [nvsb_pkg::POS_W-1:0]   bar_rem_r, bar_rem_nxt;
  logic [6:0]                   ramp_q_r, ramp_q_nxt;
  logic [7:0]                   ramp_r_r, ramp_r_nxt;
  logic                         done_r, done_nxt;
  logic [nvsb_pkg::DIM_W-1:0]   w_eff;
  logic [nvsb_pkg::DIM_W-1:0]   shifted;
  logic                         qbit;
  logic [nvsb_pkg::POS_W-1:0]   rem_step;
  logic [nvsb_pkg::POS_W-1:0]   dvd_step;
  logic                         cfg_acc;
  logic                         cfg_hit;
  logic                         busy;

  assign w_eff     = nvsb_pkg::eff_dim(width_r);
  assign busy      = (state_r != ST_IDLE) || done_r;
  assign cfg_ready = !busy;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_acc && ((cfg_index == nvsb_pkg::CFG_IDX_WIDTH) ||
                                 (cfg_index == nvsb_pkg::CFG_IDX_HEIGHT));

  // one restoring division step
  assign shifted  = {rem_r, dvd_r[nvsb_pkg::POS_W-1]};
  assign qbit     = (shifted >= w_eff);
  assign rem_step = qbit ? nvsb_pkg::POS_W'(shifted - w_eff)
                         : shifted[nvsb_pkg::POS_W-1:0];
  assign dvd_step = {dvd_r[nvsb_pkg::POS_W-2:0], qbit};

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    dvd_nxt     = dvd_r;
    rem_nxt     = rem_r;
    bar_rem_nxt = bar_rem_r;
    ramp_q_nxt  = ramp_q_r;
    ramp_r_nxt  = ramp_r_r;
    done_nxt    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (cfg_hit) begin
          if (cfg_index == nvsb_pkg::CFG_IDX_WIDTH) width_nxt = cfg_data;
          else height_nxt = cfg_data;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        dvd_nxt   = bar_in;
        rem_nxt   = '0;
        cnt_nxt   = 4'd0;
        state_nxt = ST_BAR;
      end
      ST_BAR: begin
        dvd_nxt = dvd_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(nvsb_pkg::POS_W - 1)) begin
          bar_rem_nxt = rem_step;
          dvd_nxt     = nvsb_pkg::POS_W'(nvsb_pkg::RAMP_SPAN);
          rem_nxt     = '0;
          cnt_nxt     = 4'd0;
          state_nxt   = ST_RAMP;
        end
      end
      ST_RAMP: begin
        dvd_nxt = dvd_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(nvsb_pkg::POS_W - 1)) begin
          ramp_q_nxt = dvd_step[6:0];
          ramp_r_nxt = rem_step[7:0];
          done_nxt   = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      cnt_r    <= 4'd0;
      width_r  <= nvsb_pkg::RESET_WIDTH;
      height_r <= nvsb_pkg::RESET_HEIGHT;
      done_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r     <= dvd_nxt;
    rem_r     <= rem_nxt;
    bar_rem_r <= bar_rem_nxt;
    ramp_q_r  <= ramp_q_nxt;
    ramp_r_r  <= ramp_r_nxt;
  end

  assign geom.w       = w_eff;
  assign geom.h       = nvsb_pkg::eff_dim(height_r);
  assign geom.busy    = busy;
  assign geom.cfg_wr  = cfg_hit;
  assign geom.done    = done_r;
  assign geom.bar_rem = bar_rem_r;
  assign geom.ramp_q  = ramp_q_r;
  assign geom.ramp_r  = ramp_r_r;

endmodule

// ===== rtl/nvsb_back.sv =====
module nvsb_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nvsb_pkg::nvsb_item_t          item,
  output logic                          item_pop,
  input  nvsb_pkg::nvsb_geom_t          geom,
  output logic [nvsb_pkg::POS_W-1:0]    bar_out,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [7:0]                    out_pixel_value,
  output logic                          out_is_chroma,
  output logic                          out_end_of_frame
);

  localparam int PW = nvsb_pkg::POS_W;
  localparam int DW = nvsb_pkg::DIM_W;

  logic [PW-1:0]               column_r, column_nxt;
  logic [PW-1:0]               line_r, line_nxt;
  logic                        chroma_r, chroma_nxt;
  logic [PW-1:0]               bar_r, bar_nxt;
  logic [nvsb_pkg::HUE_W-1:0]  hue_r, hue_nxt;
  logic [7:0]                  q_r, q_nxt;
  logic [PW-1:0]               r_r, r_nxt;

  nvsb_pkg::nvsb_pixel_t       omem_r [2];
  logic                        owr_ptr_r, owr_ptr_nxt;
  logic                        ord_ptr_r, ord_ptr_nxt;
  logic [1:0]                  ocnt_r, ocnt_nxt;
  logic                        opop;

  logic                        go;
  logic [PW-1:0]               col_e, line_e, bar_e, bar_gap;
  logic                        chr_e;
  logic [nvsb_pkg::HUE_W-1:0]  hue_e;
  logic [7:0]                  q_e;
  logic [PW-1:0]               r_e;
  logic [DW-1:0]               col_inc, line_inc, rs, t0, t1, t2, t3;
  logic                        wrap, plane_done;
  nvsb_pkg::nvsb_pixel_t       pix;

  assign go       = item.valid && (ocnt_r != 2'd2) && !geom.busy;
  assign item_pop = go;
  assign bar_out  = bar_r;
  assign opop     = out_pop && (ocnt_r != 2'd0);

  always_comb begin
    col_e  = item.restart ? '0 : column_r;
    line_e = item.restart ? '0 : line_r;
    chr_e  = item.restart ? 1'b0 : chroma_r;
    bar_e  = item.restart ? '0 : bar_r;
    hue_e  = item.restart ? '0 : hue_r;
    q_e    = item.restart ? '0 : q_r;
    r_e    = item.restart ? '0 : r_r;

    bar_gap = (col_e > bar_e) ? col_e - bar_e : bar_e - col_e;
    if (chr_e) begin
      pix.pixel_value = col_e[0] ? nvsb_pkg::hue_v(hue_e) : nvsb_pkg::hue_u(hue_e);
    end else if (bar_gap < PW'(nvsb_pkg::BAR_HALF)) begin
      pix.pixel_value = nvsb_pkg::BAR_LEVEL;
    end else begin
      pix.pixel_value = nvsb_pkg::RAMP_BASE + q_e;
    end
    pix.is_chroma = chr_e;

    col_inc    = {1'b0, col_e} + DW'(1);
    line_inc   = {1'b0, line_e} + DW'(1);
    wrap       = (col_inc >= geom.w);
    plane_done = chr_e ? (line_inc >= {1'b0, geom.h[DW-1:1]}) : (line_inc >= geom.h);
    pix.end_of_frame = wrap && plane_done && chr_e;

    // ramp quotient and remainder of column * span / width
    rs = {1'b0, r_e} + DW'(geom.ramp_r);

    // bar advance modulo width; narrow widths may need several subtractions
    t0 = {1'b0, bar_e} + DW'(nvsb_pkg::BAR_STEP);
    t1 = (t0 >= geom.w) ? t0 - geom.w : t0;
    t2 = (t1 >= geom.w) ? t1 - geom.w : t1;
    t3 = (t2 >= geom.w) ? t2 - geom.w : t2;

    column_nxt = column_r;
    line_nxt   = line_r;
    chroma_nxt = chroma_r;
    bar_nxt    = bar_r;
    hue_nxt    = hue_r;
    q_nxt      = q_r;
    r_nxt      = r_r;

    if (go) begin
      column_nxt = col_inc[PW-1:0];
      line_nxt   = line_e;
      chroma_nxt = chr_e;
      bar_nxt    = bar_e;
      hue_nxt    = hue_e;
      if (rs >= geom.w) begin
        r_nxt = PW'(rs - geom.w);
        q_nxt = q_e + {1'b0, geom.ramp_q} + 8'd1;
      end else begin
        r_nxt = rs[PW-1:0];
        q_nxt = q_e + {1'b0, geom.ramp_q};
      end
      if (wrap) begin
        column_nxt = '0;
        q_nxt      = '0;
        r_nxt      = '0;
        line_nxt   = line_inc[PW-1:0];
        if (plane_done) begin
          line_nxt   = '0;
          chroma_nxt = !chr_e;
          if (chr_e) begin
            bar_nxt = t3[PW-1:0];
            hue_nxt = (hue_e == nvsb_pkg::HUE_W'(nvsb_pkg::HUE_STEPS - 1)) ? '0
                      : hue_e + nvsb_pkg::HUE_W'(1);
          end
        end
      end
    end

    if (geom.cfg_wr) begin
      column_nxt = '0;
      line_nxt   = '0;
      chroma_nxt = 1'b0;
      q_nxt      = '0;
      r_nxt      = '0;
    end
    if (geom.done) begin
      bar_nxt = geom.bar_rem;
    end

    owr_ptr_nxt = go ? ~owr_ptr_r : owr_ptr_r;
    ord_ptr_nxt = opop ? ~ord_ptr_r : ord_ptr_r;
    ocnt_nxt    = ocnt_r + {1'b0, go} - {1'b0, opop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r  <= '0;
      line_r    <= '0;
      chroma_r  <= 1'b0;
      bar_r     <= '0;
      hue_r     <= '0;
      q_r       <= '0;
      r_r       <= '0;
      owr_ptr_r <= 1'b0;
      ord_ptr_r <= 1'b0;
      ocnt_r    <= 2'd0;
    end else begin
      column_r  <= column_nxt;
      line_r    <= line_nxt;
      chroma_r  <= chroma_nxt;
      bar_r     <= bar_nxt;
      hue_r     <= hue_nxt;
      q_r       <= q_nxt;
      r_r       <= r_nxt;
      owr_ptr_r <= owr_ptr_nxt;
      ord_ptr_r <= ord_ptr_nxt;
      ocnt_r    <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      omem_r[owr_ptr_r] <= pix;
    end
  end

  assign out_empty        = (ocnt_r == 2'd0);
  assign out_pixel_value  = omem_r[ord_ptr_r].pixel_value;
  assign out_is_chroma    = omem_r[ord_ptr_r].is_chroma;
  assign out_end_of_frame = omem_r[ord_ptr_r].end_of_frame;

endmodule

// ===== rtl/nv12_scrolling_bar_pattern_gen.sv =====
// channel   | ports                                   | transfer
// ----------+-----------------------------------------+------------------------
// input     | in_push, in_full, in_restart            | in_push & !in_full
// result    | out_pop, out_empty, out_pixel_value,    | out_pop & !out_empty
//           | out_is_chroma, out_end_of_frame         |
// config    | cfg_valid, cfg_ready, cfg_index,        | cfg_valid & cfg_ready
//           | cfg_data                                |
//
// One byte per cycle sustained while no queue stalls: an item goes through a 2-entry
// input queue and the generator into a 2-entry result queue, registered in each queue
// before it reaches the result ports. After reset and after each write to the width
// or height register a shift-subtract divider (bar wrap, then ramp step 200/width)
// keeps full high and cfg_ready low while it runs. Either queue may stall on its own;
// a full result queue halts the generator.
module nv12_scrolling_bar_pattern_gen (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic                        in_restart,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [7:0]                  out_pixel_value,
  output logic                        out_is_chroma,
  output logic                        out_end_of_frame,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [nvsb_pkg::DIM_W-1:0]  cfg_data
);

  nvsb_pkg::nvsb_item_t             item;
  nvsb_pkg::nvsb_geom_t             geom;
  logic                             item_pop;
  logic [nvsb_pkg::POS_W-1:0]       bar_pos;

  nvsb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_restart (in_restart),
    .in_full    (in_full),
    .busy       (geom.busy),
    .item_pop   (item_pop),
    .item       (item)
  );

  nvsb_setup u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bar_in    (bar_pos),
    .geom      (geom)
  );

  nvsb_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .item             (item),
    .item_pop         (item_pop),
    .geom             (geom),
    .bar_out          (bar_pos),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pixel_value  (out_pixel_value),
    .out_is_chroma    (out_is_chroma),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule
